/* rtl/scsa_pkg.sv */
package scsa_pkg;

  localparam int GRAN_SHIFT  = 4;
  localparam int OWNER_BYTES = 16;
  localparam int TABLE_SLOTS = 32;
  localparam int CLASS_W     = 5;
  localparam int BYTES_W     = 10;

  typedef enum logic [1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE_SIZED = 2'd1,
    CMD_FREE       = 2'd2,
    CMD_QUERY      = 2'd3
  } scsa_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_NOT_HANDLED = 2'd1,
    ST_EXHAUSTED   = 2'd2,
    ST_NULL        = 2'd3
  } scsa_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OWNER,
    S_CLASS,
    S_LINK
  } scsa_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_bytes;
    logic [31:0] address;
  } scsa_req_t;

  typedef struct packed {
    logic [31:0]        result_address;
    logic [1:0]         status;
    logic [BYTES_W-1:0] class_bytes;
    logic [CLASS_W-1:0] class_index;
  } scsa_rsp_t;

  typedef struct packed {
    logic is_null;
    logic class_ok;
    logic in_pool;
  } scsa_dec_t;

  function automatic logic [BYTES_W-1:0] class_size_of(input logic [CLASS_W-1:0] idx);
    logic [BYTES_W-1:0] sz;
    case (idx)
      5'd0:    sz = 10'd16;
      5'd1:    sz = 10'd32;
      5'd2:    sz = 10'd48;
      5'd3:    sz = 10'd64;
      5'd4:    sz = 10'd80;
      5'd5:    sz = 10'd96;
      5'd6:    sz = 10'd112;
      5'd7:    sz = 10'd128;
      5'd8:    sz = 10'd160;
      5'd9:    sz = 10'd192;
      5'd10:   sz = 10'd224;
      5'd11:   sz = 10'd256;
      5'd12:   sz = 10'd288;
      5'd13:   sz = 10'd320;
      5'd14:   sz = 10'd352;
      5'd15:   sz = 10'd384;
      5'd16:   sz = 10'd416;
      5'd17:   sz = 10'd448;
      5'd18:   sz = 10'd480;
      5'd19:   sz = 10'd512;
      default: sz = 10'd0;
    endcase
    return sz;
  endfunction

endpackage

/* rtl/size_class_slab_allocator.sv */
// Path to the done strobe: a null address or a request rejected at decode ends in S_DECODE,
// a query in S_OWNER, a sized free, a carve or an exhausted alloc in S_CLASS, a pop in
// S_LINK after S_CLASS, an unsized free in S_CLASS after S_OWNER; done_o is registered.
// One transaction at a time; a new one is taken in the cycle its predecessor's result shows,
// and none before that. The receiver cannot stall; done_o lasts one cycle.
// Reset empties all lists, claims no hunk and sets pool_base to 65536; no clearing pass.
module size_class_slab_allocator import scsa_pkg::*; #(
  parameter int NUM_HUNKS = 16,
  parameter int HUNK_SHIFT = 16,
  parameter int NUM_CLASSES = 20,
  parameter int MAX_SMALL_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  scsa_req_t   req_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output scsa_rsp_t   rsp_o
);

  localparam int LINK_DEPTH = NUM_HUNKS << (HUNK_SHIFT - GRAN_SHIFT);
  localparam int GW   = $clog2(LINK_DEPTH);
  localparam int LW   = $clog2(LINK_DEPTH + 1);
  localparam int HW   = (NUM_HUNKS > 1) ? $clog2(NUM_HUNKS) : 1;
  localparam int CNTW = $clog2(NUM_HUNKS + 1);
  localparam int CAW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int OW   = HUNK_SHIFT + 1;
  localparam int ROWW = LW + HW + OW;
  localparam logic [31:0] HunkMask = ~((32'd1 << HUNK_SHIFT) - 32'd1);
  localparam logic [OW-1:0] Usable = OW'((1 << HUNK_SHIFT) - OWNER_BYTES);

  scsa_state_e state_q, state_d;
  scsa_req_t   req_q, req_d;
  logic [CLASS_W-1:0] cls_q, cls_d;
  logic [GW-1:0]      gran_q, gran_d;
  logic [CNTW-1:0]    claimed_q, claimed_d;
  logic [NUM_CLASSES-1:0] row_written_q, row_written_d;
  logic [NUM_CLASSES-1:0] carve_valid_q, carve_valid_d;
  logic [31:0] base_q, base_d;
  scsa_rsp_t   rsp_q, rsp_d;
  logic        done_q, done_d;

  scsa_dec_t          dec;
  logic [CLASS_W-1:0] dec_cls;
  logic [GW-1:0]      dec_gran;
  logic [HW-1:0]      dec_hunk;

  logic            class_we, class_re;
  logic [CAW-1:0]  class_raddr;
  logic [ROWW-1:0] class_wdata, class_rdata;
  logic            owner_we, owner_re;
  logic [CLASS_W-1:0] owner_rdata;
  logic            link_we, link_re;
  logic [GW-1:0]   link_raddr;
  logic [LW-1:0]   link_wdata, link_rdata;

  logic [31:0]     base;
  logic [LW-1:0]   row_head;
  logic [HW-1:0]   row_hunk;
  logic [OW-1:0]   row_off;
  logic [BYTES_W-1:0] cb;
  logic [OW-1:0]   off_end;
  logic [32:0]     hunk_base;
  logic [HW-1:0]   use_hunk;
  logic [OW-1:0]   use_off;
  logic            need_claim;
  logic            hunk_claimed;

  function automatic scsa_rsp_t make_rsp(input logic [31:0] addr, input scsa_status_e st,
                                         input logic has_cls, input logic [CLASS_W-1:0] c);
    scsa_rsp_t r;
    r.result_address = addr;
    r.status         = st;
    r.class_bytes    = has_cls ? class_size_of(c) : '0;
    r.class_index    = has_cls ? c : '0;
    return r;
  endfunction

  scsa_decode #(
    .NUM_HUNKS(NUM_HUNKS),
    .HUNK_SHIFT(HUNK_SHIFT),
    .NUM_CLASSES(NUM_CLASSES),
    .MAX_SMALL_BYTES(MAX_SMALL_BYTES)
  ) u_decode (
    .req_i(req_q),
    .pool_base_i(base_q),
    .dec_o(dec),
    .cls_o(dec_cls),
    .gran_o(dec_gran),
    .hunk_o(dec_hunk)
  );

  scsa_ram #(.WIDTH(ROWW), .DEPTH(NUM_CLASSES)) u_class_ram (
    .clk_i(clk_i),
    .we_i(class_we),
    .waddr_i(cls_q[CAW-1:0]),
    .wdata_i(class_wdata),
    .re_i(class_re),
    .raddr_i(class_raddr),
    .rdata_o(class_rdata)
  );

  scsa_ram #(.WIDTH(CLASS_W), .DEPTH(NUM_HUNKS)) u_owner_ram (
    .clk_i(clk_i),
    .we_i(owner_we),
    .waddr_i(claimed_q[HW-1:0]),
    .wdata_i(cls_q),
    .re_i(owner_re),
    .raddr_i(dec_hunk),
    .rdata_o(owner_rdata)
  );

  scsa_ram #(.WIDTH(LW), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk_i(clk_i),
    .we_i(link_we),
    .waddr_i(gran_q),
    .wdata_i(link_wdata),
    .re_i(link_re),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  assign base         = base_q & HunkMask;
  assign hunk_claimed = ({1'b0, CNTW'(dec_hunk)} < {1'b0, claimed_q});
  assign row_head     = row_written_q[cls_q[CAW-1:0]] ? class_rdata[ROWW-1 -: LW] : '0;
  assign row_hunk     = class_rdata[OW+HW-1:OW];
  assign row_off      = class_rdata[OW-1:0];
  assign cb           = class_size_of(cls_q);
  assign off_end      = row_off + OW'(cb);
  assign need_claim   = !carve_valid_q[cls_q[CAW-1:0]] || (off_end > Usable);
  assign hunk_base    = {1'b0, base} + (33'(claimed_q) << HUNK_SHIFT);
  assign use_hunk     = need_claim ? claimed_q[HW-1:0] : row_hunk;
  assign use_off      = need_claim ? '0 : row_off;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    cls_d         = cls_q;
    gran_d        = gran_q;
    claimed_d     = claimed_q;
    row_written_d = row_written_q;
    carve_valid_d = carve_valid_q;
    base_d        = cfg_we_i ? cfg_wdata_i : base_q;
    rsp_d         = rsp_q;
    done_d        = 1'b0;
    class_we      = 1'b0;
    class_re      = 1'b0;
    class_raddr   = dec_cls[CAW-1:0];
    class_wdata   = class_rdata;
    owner_we      = 1'b0;
    owner_re      = 1'b0;
    link_we       = 1'b0;
    link_re       = 1'b0;
    link_raddr    = GW'(row_head - LW'(1));
    link_wdata    = row_head;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        gran_d = dec_gran;
        if (req_q.command == CMD_ALLOC) begin
          if (!dec.class_ok) begin
            rsp_d   = make_rsp('0, ST_NOT_HANDLED, 1'b0, '0);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            cls_d    = dec_cls;
            class_re = 1'b1;
            state_d  = S_CLASS;
          end
        end else if (dec.is_null) begin
          rsp_d   = make_rsp('0, ST_NULL, 1'b0, '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (req_q.command == CMD_FREE_SIZED) begin
          if (!dec.class_ok || !dec.in_pool) begin
            rsp_d   = make_rsp('0, ST_NOT_HANDLED, 1'b0, '0);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            cls_d    = dec_cls;
            class_re = 1'b1;
            state_d  = S_CLASS;
          end
        end else begin
          if (!dec.in_pool || !hunk_claimed) begin
            rsp_d   = make_rsp('0, ST_NOT_HANDLED, 1'b0, '0);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            owner_re = 1'b1;
            state_d  = S_OWNER;
          end
        end
      end
      S_OWNER: begin
        class_raddr = owner_rdata[CAW-1:0];
        if ({1'b0, owner_rdata} >= 6'(NUM_CLASSES)) begin
          rsp_d   = make_rsp('0, ST_NOT_HANDLED, 1'b0, '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (req_q.command == CMD_QUERY) begin
          rsp_d   = make_rsp('0, ST_DONE, 1'b1, owner_rdata);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cls_d    = owner_rdata;
          class_re = 1'b1;
          state_d  = S_CLASS;
        end
      end
      S_CLASS: begin
        if (req_q.command != CMD_ALLOC) begin
          link_we     = 1'b1;
          class_we    = 1'b1;
          class_wdata = {LW'(gran_q) + LW'(1), row_hunk, row_off};
          row_written_d[cls_q[CAW-1:0]] = 1'b1;
          rsp_d   = make_rsp('0, ST_DONE, 1'b1, cls_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (row_head != '0) begin
          link_re = 1'b1;
          rsp_d   = make_rsp(base + (32'(link_raddr) << GRAN_SHIFT), ST_DONE, 1'b1, cls_q);
          state_d = S_LINK;
        end else if (need_claim &&
                     ((claimed_q >= CNTW'(NUM_HUNKS)) || hunk_base[32])) begin
          rsp_d   = make_rsp('0, ST_EXHAUSTED, 1'b1, cls_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (need_claim) begin
            owner_we  = 1'b1;
            claimed_d = claimed_q + CNTW'(1);
            carve_valid_d[cls_q[CAW-1:0]] = 1'b1;
          end
          class_we    = 1'b1;
          class_wdata = {LW'(0), use_hunk, use_off + OW'(cb)};
          row_written_d[cls_q[CAW-1:0]] = 1'b1;
          rsp_d   = make_rsp(base + (32'(use_hunk) << HUNK_SHIFT) + 32'(use_off),
                             ST_DONE, 1'b1, cls_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LINK: begin
        class_we    = 1'b1;
        class_wdata = {link_rdata, row_hunk, row_off};
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      claimed_q     <= '0;
      row_written_q <= '0;
      carve_valid_q <= '0;
      base_q        <= 32'd65536;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      claimed_q     <= claimed_d;
      row_written_q <= row_written_d;
      carve_valid_q <= carve_valid_d;
      base_q        <= base_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cls_q  <= cls_d;
    gran_q <= gran_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/scsa_ram.sv */
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/scsa_decode.sv */
module scsa_decode import scsa_pkg::*; #(
  parameter int NUM_HUNKS = 16,
  parameter int HUNK_SHIFT = 16,
  parameter int NUM_CLASSES = 20,
  parameter int MAX_SMALL_BYTES = 512,
  localparam int LINK_DEPTH = NUM_HUNKS << (HUNK_SHIFT - GRAN_SHIFT),
  localparam int GW = $clog2(LINK_DEPTH),
  localparam int HW = (NUM_HUNKS > 1) ? $clog2(NUM_HUNKS) : 1
) (
  input  scsa_req_t           req_i,
  input  logic [31:0]         pool_base_i,
  output scsa_dec_t           dec_o,
  output logic [CLASS_W-1:0]  cls_o,
  output logic [GW-1:0]       gran_o,
  output logic [HW-1:0]       hunk_o
);

  localparam logic [31:0] HunkMask = ~((32'd1 << HUNK_SHIFT) - 32'd1);
  localparam logic [32:0] PoolSpan = 33'(NUM_HUNKS) << HUNK_SHIFT;

  logic [31:0] base;
  logic [32:0] pool_end;
  logic [31:0] diff;
  logic        found;
  logic [CLASS_W-1:0] cls;

  assign base     = pool_base_i & HunkMask;
  assign pool_end = {1'b0, base} + PoolSpan;
  assign diff     = req_i.address - base;

  always_comb begin
    found = 1'b0;
    cls   = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!found && (i < NUM_CLASSES) && (class_size_of(CLASS_W'(i)) != '0) &&
          (32'(class_size_of(CLASS_W'(i))) >= req_i.request_bytes)) begin
        found = 1'b1;
        cls   = CLASS_W'(i);
      end
    end
  end

  assign cls_o            = cls;
  assign dec_o.class_ok   = found && (req_i.request_bytes <= 32'(MAX_SMALL_BYTES));
  assign dec_o.is_null    = (req_i.address == 32'd0);
  assign dec_o.in_pool    = ({1'b0, req_i.address} >= {1'b0, base}) &&
                            ({1'b0, req_i.address} < pool_end);
  assign gran_o           = diff[GW+GRAN_SHIFT-1:GRAN_SHIFT];
  assign hunk_o           = diff[HUNK_SHIFT+HW-1:HUNK_SHIFT];

endmodule
